### design/pdfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D frame decoder package
// Shared constants, codes and types of the frame decoder.
// ----------------------------------------------------------------------------
package pdfd_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam int unsigned FRAME_BYTES  = 7;
  localparam int unsigned BODY_BYTES   = FRAME_BYTES - 2;
  localparam int unsigned POS_W        = $clog2(FRAME_BYTES);

  localparam logic [7:0]  EXT_MIN_OP   = 8'h49;
  localparam logic [7:0]  HOME_DATA    = 8'h22;
  localparam logic [7:0]  FLIP_DATA    = 8'h21;
  localparam logic [7:0]  SPEED_TOP    = 8'h3F;
  localparam logic [7:0]  SPEED_TURBO  = 8'h40;

  localparam logic [7:0]  OWN_ADDRESS_RST   = 8'd1;
  localparam logic [15:0] PAN_MIN_RATE_RST  = 16'd500;
  localparam logic [15:0] PAN_MAX_RATE_RST  = 16'd12000;
  localparam logic [15:0] TILT_MIN_RATE_RST = 16'd500;
  localparam logic [15:0] TILT_MAX_RATE_RST = 16'd13000;

  // Division by 63 is done as a multiplication by ceil(2^28 / 63).
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned SCALE_W     = 29;
  localparam logic [SCALE_W-1:0] RECIP_63 = 29'd4260881;

  typedef enum logic [2:0] {
    CFG_OWN_ADDRESS   = 3'd0,
    CFG_PAN_MIN_RATE  = 3'd1,
    CFG_PAN_MAX_RATE  = 3'd2,
    CFG_TILT_MIN_RATE = 3'd3,
    CFG_TILT_MAX_RATE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_BAD_CHECKSUM = 2'd1,
    ST_NOT_OURS     = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    ACT_NONE          = 6'd0,
    ACT_SET_PRESET    = 6'd1,
    ACT_CLEAR_PRESET  = 6'd2,
    ACT_GO_HOME       = 6'd3,
    ACT_FLIP          = 6'd4,
    ACT_GOTO_PRESET   = 6'd5,
    ACT_SET_AUX       = 6'd6,
    ACT_CLEAR_AUX     = 6'd7,
    ACT_REMOTE_RESET  = 6'd8,
    ACT_ZONE_START    = 6'd9,
    ACT_ZONE_END      = 6'd10,
    ACT_CLEAR_SCREEN  = 6'd11,
    ACT_ALARM_ACK     = 6'd12,
    ACT_ZONE_SCAN_ON  = 6'd13,
    ACT_ZONE_SCAN_OFF = 6'd14,
    ACT_PATTERN_START = 6'd15,
    ACT_PATTERN_STOP  = 6'd16,
    ACT_RUN_PATTERN   = 6'd17,
    ACT_RESET_CAMERA  = 6'd18,
    ACT_AUTOFOCUS     = 6'd19,
    ACT_AUTO_IRIS     = 6'd20,
    ACT_BACKLIGHT     = 6'd21,
    ACT_AUTO_WB       = 6'd22,
    ACT_SHUTTER       = 6'd23,
    ACT_SET_ZERO      = 6'd24,
    ACT_SET_PAN_POS   = 6'd25,
    ACT_SET_TILT_POS  = 6'd26,
    ACT_SET_ZOOM_POS  = 6'd27,
    ACT_QUERY_PAN     = 6'd28,
    ACT_QUERY_TILT    = 6'd29,
    ACT_QUERY_ZOOM    = 6'd30,
    ACT_SET_MAG       = 6'd31,
    ACT_QUERY_MAG     = 6'd32,
    ACT_STOP          = 6'd33,
    ACT_UP_LEFT       = 6'd34,
    ACT_UP_RIGHT      = 6'd35,
    ACT_DOWN_LEFT     = 6'd36,
    ACT_DOWN_RIGHT    = 6'd37,
    ACT_PAN_LEFT      = 6'd38,
    ACT_PAN_RIGHT     = 6'd39,
    ACT_TILT_UP       = 6'd40,
    ACT_TILT_DOWN     = 6'd41,
    ACT_ZOOM_IN       = 6'd42,
    ACT_ZOOM_OUT      = 6'd43,
    ACT_FOCUS_FAR     = 6'd44,
    ACT_FOCUS_NEAR    = 6'd45,
    ACT_IRIS_OPEN     = 6'd46,
    ACT_IRIS_CLOSE    = 6'd47,
    ACT_CAMERA_ON     = 6'd48,
    ACT_CAMERA_OFF    = 6'd49,
    ACT_AUTO_SCAN_ON  = 6'd50,
    ACT_AUTO_SCAN_OFF = 6'd51
  } action_e;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] csum;
  } frame_t;

  typedef struct packed {
    status_e     status;
    action_e     action;
    logic [7:0]  preset;
    logic [7:0]  aux;
    logic [15:0] position;
  } cmd_t;

  function automatic logic [SCALE_W-1:0] step_scale(input logic [5:0] speed);
    step_scale = SCALE_W'(speed) * RECIP_63;
  endfunction

endpackage

### design/pdfd_frame_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D frame assembler
// Collects received bytes into a frame and holds each complete frame until
// the decoder takes it.
// ----------------------------------------------------------------------------
module pdfd_frame_assembler
  import pdfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       drain_i,
  output logic       frame_valid_o,
  output frame_t     frame_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       body_q [BODY_BYTES];
  logic             valid_q, valid_d;
  frame_t           frame_q;
  logic             load;
  logic             store;
  logic [POS_W-1:0] slot;

  assign slot  = pos_q - POS_W'(1);
  assign store = accept_i && (rx_byte_i != SYNC_BYTE) && (pos_q != '0)
                 && (pos_q < POS_W'(FRAME_BYTES - 1));
  assign load  = accept_i && (rx_byte_i != SYNC_BYTE)
                 && (pos_q == POS_W'(FRAME_BYTES - 1));

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (rx_byte_i == SYNC_BYTE) begin
        pos_d = POS_W'(1);
      end else if (store) begin
        pos_d = pos_q + POS_W'(1);
      end else if (load) begin
        pos_d = '0;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BODY_BYTES; i++) begin
      if (store && (slot == POS_W'(i))) begin
        body_q[i] <= rx_byte_i;
      end
    end
    if (load) begin
      frame_q.addr  <= body_q[0];
      frame_q.cmd1  <= body_q[1];
      frame_q.cmd2  <= body_q[2];
      frame_q.data1 <= body_q[3];
      frame_q.data2 <= body_q[4];
      frame_q.csum  <= rx_byte_i;
    end
  end

  assign frame_valid_o = valid_q;
  assign frame_o       = frame_q;

endmodule

### design/pdfd_cmd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D command decode
// Checks checksum and address of a frame and decodes its action, preset or
// aux id and position word.
// ----------------------------------------------------------------------------
module pdfd_cmd_decode
  import pdfd_pkg::*;
(
  input  frame_t     frame_i,
  input  logic [7:0] own_address_i,
  output cmd_t       cmd_o
);

  localparam logic [7:0] OP_SET_PRESET    = 8'h03;
  localparam logic [7:0] OP_CLEAR_PRESET  = 8'h05;
  localparam logic [7:0] OP_GOTO_PRESET   = 8'h07;
  localparam logic [7:0] OP_SET_AUX       = 8'h09;
  localparam logic [7:0] OP_CLEAR_AUX     = 8'h0B;
  localparam logic [7:0] OP_REMOTE_RESET  = 8'h0F;
  localparam logic [7:0] OP_ZONE_START    = 8'h11;
  localparam logic [7:0] OP_ZONE_END      = 8'h13;
  localparam logic [7:0] OP_CLEAR_SCREEN  = 8'h17;
  localparam logic [7:0] OP_ALARM_ACK     = 8'h19;
  localparam logic [7:0] OP_ZONE_SCAN_ON  = 8'h1B;
  localparam logic [7:0] OP_ZONE_SCAN_OFF = 8'h1D;
  localparam logic [7:0] OP_PATTERN_START = 8'h1F;
  localparam logic [7:0] OP_PATTERN_STOP  = 8'h21;
  localparam logic [7:0] OP_RUN_PATTERN   = 8'h23;
  localparam logic [7:0] OP_RESET_CAMERA  = 8'h29;
  localparam logic [7:0] OP_AUTOFOCUS     = 8'h2B;
  localparam logic [7:0] OP_AUTO_IRIS     = 8'h2D;
  localparam logic [7:0] OP_BACKLIGHT     = 8'h31;
  localparam logic [7:0] OP_AUTO_WB       = 8'h33;
  localparam logic [7:0] OP_SHUTTER       = 8'h37;
  localparam logic [7:0] OP_SET_ZERO      = 8'h49;
  localparam logic [7:0] OP_SET_PAN_POS   = 8'h4B;
  localparam logic [7:0] OP_SET_TILT_POS  = 8'h4D;
  localparam logic [7:0] OP_SET_ZOOM_POS  = 8'h4F;
  localparam logic [7:0] OP_QUERY_PAN     = 8'h51;
  localparam logic [7:0] OP_QUERY_TILT    = 8'h53;
  localparam logic [7:0] OP_QUERY_ZOOM    = 8'h55;
  localparam logic [7:0] OP_SET_MAG       = 8'h5F;
  localparam logic [7:0] OP_QUERY_MAG     = 8'h61;

  logic [7:0] c1;
  logic [7:0] c2;
  logic [7:0] sum;
  logic       extended;
  action_e    std_act;

  assign c1  = frame_i.cmd1;
  assign c2  = frame_i.cmd2;
  assign sum = frame_i.addr + c1 + c2 + frame_i.data1 + frame_i.data2;
  assign extended = (c1 == 8'h00) && (c2 != 8'h00) && (c2[0] || (c2 >= EXT_MIN_OP));

  always_comb begin
    std_act = ACT_NONE;
    if (c2[2] && c2[3]) begin
      std_act = ACT_UP_LEFT;
    end else if (c2[1] && c2[3]) begin
      std_act = ACT_UP_RIGHT;
    end else if (c2[2] && c2[4]) begin
      std_act = ACT_DOWN_LEFT;
    end else if (c2[1] && c2[4]) begin
      std_act = ACT_DOWN_RIGHT;
    end else if (c2[2]) begin
      std_act = ACT_PAN_LEFT;
    end else if (c2[1]) begin
      std_act = ACT_PAN_RIGHT;
    end else if (c2[3]) begin
      std_act = ACT_TILT_UP;
    end else if (c2[4]) begin
      std_act = ACT_TILT_DOWN;
    end else if (c2[5]) begin
      std_act = ACT_ZOOM_IN;
    end else if (c2[6]) begin
      std_act = ACT_ZOOM_OUT;
    end else if (c2[7]) begin
      std_act = ACT_FOCUS_FAR;
    end else if (c1[1]) begin
      std_act = ACT_FOCUS_NEAR;
    end else if (c1[2]) begin
      std_act = ACT_IRIS_OPEN;
    end else if (c1[3]) begin
      std_act = ACT_IRIS_CLOSE;
    end else if (c1[4]) begin
      std_act = c1[7] ? ACT_CAMERA_ON : ACT_CAMERA_OFF;
    end else if (c1[5]) begin
      std_act = c1[7] ? ACT_AUTO_SCAN_ON : ACT_AUTO_SCAN_OFF;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.status   = ST_ACCEPTED;
    cmd_o.action   = ACT_NONE;
    if (sum != frame_i.csum) begin
      cmd_o.status = ST_BAD_CHECKSUM;
    end else if ((frame_i.addr != own_address_i) && (frame_i.addr != 8'h00)) begin
      cmd_o.status = ST_NOT_OURS;
    end else if (extended) begin
      cmd_o.position = {frame_i.data1, frame_i.data2};
      case (c2)
        OP_SET_PRESET: begin
          cmd_o.action = ACT_SET_PRESET;
          cmd_o.preset = frame_i.data2;
        end
        OP_CLEAR_PRESET: begin
          cmd_o.action = ACT_CLEAR_PRESET;
          cmd_o.preset = frame_i.data2;
        end
        OP_GOTO_PRESET: begin
          if (frame_i.data2 == HOME_DATA) begin
            cmd_o.action = ACT_GO_HOME;
          end else if (frame_i.data2 == FLIP_DATA) begin
            cmd_o.action = ACT_FLIP;
          end else begin
            cmd_o.action = ACT_GOTO_PRESET;
            cmd_o.preset = frame_i.data2;
          end
        end
        OP_SET_AUX: begin
          cmd_o.action = ACT_SET_AUX;
          cmd_o.aux    = frame_i.data2;
        end
        OP_CLEAR_AUX: begin
          cmd_o.action = ACT_CLEAR_AUX;
          cmd_o.aux    = frame_i.data2;
        end
        OP_REMOTE_RESET: cmd_o.action = ACT_REMOTE_RESET;
        OP_ZONE_START: begin
          cmd_o.action = ACT_ZONE_START;
          cmd_o.aux    = frame_i.data2;
        end
        OP_ZONE_END: begin
          cmd_o.action = ACT_ZONE_END;
          cmd_o.aux    = frame_i.data2;
        end
        OP_CLEAR_SCREEN: cmd_o.action = ACT_CLEAR_SCREEN;
        OP_ALARM_ACK: begin
          cmd_o.action = ACT_ALARM_ACK;
          cmd_o.aux    = frame_i.data2;
        end
        OP_ZONE_SCAN_ON:  cmd_o.action = ACT_ZONE_SCAN_ON;
        OP_ZONE_SCAN_OFF: cmd_o.action = ACT_ZONE_SCAN_OFF;
        OP_PATTERN_START: begin
          cmd_o.action = ACT_PATTERN_START;
          cmd_o.preset = frame_i.data2;
        end
        OP_PATTERN_STOP: cmd_o.action = ACT_PATTERN_STOP;
        OP_RUN_PATTERN: begin
          cmd_o.action = ACT_RUN_PATTERN;
          cmd_o.preset = frame_i.data2;
        end
        OP_RESET_CAMERA:  cmd_o.action = ACT_RESET_CAMERA;
        OP_AUTOFOCUS:     cmd_o.action = ACT_AUTOFOCUS;
        OP_AUTO_IRIS:     cmd_o.action = ACT_AUTO_IRIS;
        OP_BACKLIGHT:     cmd_o.action = ACT_BACKLIGHT;
        OP_AUTO_WB:       cmd_o.action = ACT_AUTO_WB;
        OP_SHUTTER:       cmd_o.action = ACT_SHUTTER;
        OP_SET_ZERO:      cmd_o.action = ACT_SET_ZERO;
        OP_SET_PAN_POS:   cmd_o.action = ACT_SET_PAN_POS;
        OP_SET_TILT_POS:  cmd_o.action = ACT_SET_TILT_POS;
        OP_SET_ZOOM_POS:  cmd_o.action = ACT_SET_ZOOM_POS;
        OP_QUERY_PAN:     cmd_o.action = ACT_QUERY_PAN;
        OP_QUERY_TILT:    cmd_o.action = ACT_QUERY_TILT;
        OP_QUERY_ZOOM:    cmd_o.action = ACT_QUERY_ZOOM;
        OP_SET_MAG:       cmd_o.action = ACT_SET_MAG;
        OP_QUERY_MAG:     cmd_o.action = ACT_QUERY_MAG;
        default:          cmd_o.action = ACT_NONE;
      endcase
    end else if ((c1 == 8'h00) && (c2 == 8'h00)) begin
      cmd_o.action = ACT_STOP;
    end else begin
      cmd_o.action = std_act;
    end
  end

endmodule

### design/pdfd_rate_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D speed to step rate map
// Maps a raw speed byte linearly onto the range between a minimum and a
// maximum step rate; speed zero gives zero and the turbo speed the maximum.
// ----------------------------------------------------------------------------
module pdfd_rate_map
  import pdfd_pkg::*;
(
  input  logic [7:0]  speed_i,
  input  logic [15:0] min_rate_i,
  input  logic [15:0] max_rate_i,
  output logic [15:0] rate_o
);

  localparam int unsigned PROD_W = SCALE_W + 16;

  logic [5:0]        speed_clamped;
  logic [15:0]       span;
  logic [PROD_W-1:0] prod;
  logic [15:0]       quot;

  assign speed_clamped = (speed_i > SPEED_TOP) ? SPEED_TOP[5:0] : speed_i[5:0];
  assign span = (max_rate_i >= min_rate_i) ? (max_rate_i - min_rate_i) : 16'd0;
  assign prod = PROD_W'(step_scale(speed_clamped)) * PROD_W'(span);
  // The quotient never exceeds the span, so 16 bits hold it.
  assign quot = prod[RECIP_SHIFT +: 16];

  always_comb begin
    if (speed_i == 8'h00) begin
      rate_o = 16'd0;
    end else if (speed_i == SPEED_TURBO) begin
      rate_o = max_rate_i;
    end else begin
      rate_o = min_rate_i + quot;
    end
  end

endmodule

### design/pelco_d_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D frame decoder
// Assembles received serial bytes into Pelco-D frames and decodes each
// complete frame into a status, an action and step rates.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one received byte per transfer; the output
// channel carries one decoded result per transfer. A byte of 0xFF always
// starts a new frame, and the seventh byte of a frame yields one result.
// Bytes before the first sync and all other bytes yield no result.
// Throughput is one byte per cycle while the input is not stalled. A frame
// is registered on its checksum byte and is decoded into the output register
// as soon as that register is free to take it.
// When the receiver stalls, the held result stays and the completed frame
// waits in its register; input is stalled only while both are occupied.
// Reset empties both registers, waits for sync and loads the default
// address and rates. Registers are written through the configuration port;
// the user must write them only while no frame is pending (not enforced).
// ----------------------------------------------------------------------------
module pelco_d_frame_decoder_unit
  import pdfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  action_o,
  output logic [7:0]  pan_raw_o,
  output logic [7:0]  tilt_raw_o,
  output logic [7:0]  preset_number_o,
  output logic [7:0]  aux_number_o,
  output logic [15:0] pos_word_o,
  output logic [15:0] pan_rate_o,
  output logic [15:0] tilt_rate_o
);

  logic [7:0]  own_address_q;
  logic [15:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;

  logic        accept;
  logic        out_ready;
  logic        drain;
  logic        frame_valid;
  frame_t      frame;
  cmd_t        cmd;
  logic        ok;
  logic [15:0] pan_rate, tilt_rate;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  logic [5:0]  action_q;
  logic [7:0]  pan_raw_q, tilt_raw_q, preset_q, aux_q;
  logic [15:0] position_q, pan_rate_q, tilt_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= OWN_ADDRESS_RST;
      pan_min_q     <= PAN_MIN_RATE_RST;
      pan_max_q     <= PAN_MAX_RATE_RST;
      tilt_min_q    <= TILT_MIN_RATE_RST;
      tilt_max_q    <= TILT_MAX_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_ADDRESS:   own_address_q <= cfg_wdata_i[7:0];
        CFG_PAN_MIN_RATE:  pan_min_q     <= cfg_wdata_i;
        CFG_PAN_MAX_RATE:  pan_max_q     <= cfg_wdata_i;
        CFG_TILT_MIN_RATE: tilt_min_q    <= cfg_wdata_i;
        CFG_TILT_MAX_RATE: tilt_max_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign drain      = frame_valid && out_ready;
  assign in_stall_o = frame_valid && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  pdfd_frame_assembler u_assembler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .drain_i       (drain),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  pdfd_cmd_decode u_decode (
    .frame_i       (frame),
    .own_address_i (own_address_q),
    .cmd_o         (cmd)
  );

  pdfd_rate_map u_pan_rate (
    .speed_i    (frame.data1),
    .min_rate_i (pan_min_q),
    .max_rate_i (pan_max_q),
    .rate_o     (pan_rate)
  );

  pdfd_rate_map u_tilt_rate (
    .speed_i    (frame.data2),
    .min_rate_i (tilt_min_q),
    .max_rate_i (tilt_max_q),
    .rate_o     (tilt_rate)
  );

  assign ok = (cmd.status == ST_ACCEPTED);

  always_comb begin
    out_valid_d = out_valid_q;
    if (drain) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      status_q    <= cmd.status;
      action_q    <= cmd.action;
      preset_q    <= cmd.preset;
      aux_q       <= cmd.aux;
      position_q  <= cmd.position;
      pan_raw_q   <= ok ? frame.data1 : 8'h00;
      tilt_raw_q  <= ok ? frame.data2 : 8'h00;
      pan_rate_q  <= ok ? pan_rate : 16'd0;
      tilt_rate_q <= ok ? tilt_rate : 16'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign action_o        = action_q;
  assign pan_raw_o       = pan_raw_q;
  assign tilt_raw_o      = tilt_raw_q;
  assign preset_number_o = preset_q;
  assign aux_number_o    = aux_q;
  assign pos_word_o      = position_q;
  assign pan_rate_o      = pan_rate_q;
  assign tilt_rate_o     = tilt_rate_q;

endmodule

### verif/pdfd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D frame decoder result checker
// Watches the byte and result channels of the frame decoder. It keeps its
// own copy of the registers and of the frame being assembled, works out the
// decoded result of every completed frame and compares each result transfer
// with the oldest outstanding decode.
// ----------------------------------------------------------------------------
package pdfd_tb_pkg;

  import pdfd_pkg::*;

  localparam logic [7:0] OP_SET_PRESET    = 8'h03;
  localparam logic [7:0] OP_CLEAR_PRESET  = 8'h05;
  localparam logic [7:0] OP_GOTO_PRESET   = 8'h07;
  localparam logic [7:0] OP_SET_AUX       = 8'h09;
  localparam logic [7:0] OP_CLEAR_AUX     = 8'h0B;
  localparam logic [7:0] OP_REMOTE_RESET  = 8'h0F;
  localparam logic [7:0] OP_ZONE_START    = 8'h11;
  localparam logic [7:0] OP_ZONE_END      = 8'h13;
  localparam logic [7:0] OP_CLEAR_SCREEN  = 8'h17;
  localparam logic [7:0] OP_ALARM_ACK     = 8'h19;
  localparam logic [7:0] OP_ZONE_SCAN_ON  = 8'h1B;
  localparam logic [7:0] OP_ZONE_SCAN_OFF = 8'h1D;
  localparam logic [7:0] OP_PATTERN_START = 8'h1F;
  localparam logic [7:0] OP_PATTERN_STOP  = 8'h21;
  localparam logic [7:0] OP_RUN_PATTERN   = 8'h23;
  localparam logic [7:0] OP_RESET_CAMERA  = 8'h29;
  localparam logic [7:0] OP_AUTOFOCUS     = 8'h2B;
  localparam logic [7:0] OP_AUTO_IRIS     = 8'h2D;
  localparam logic [7:0] OP_BACKLIGHT     = 8'h31;
  localparam logic [7:0] OP_AUTO_WB       = 8'h33;
  localparam logic [7:0] OP_SHUTTER       = 8'h37;
  localparam logic [7:0] OP_SET_ZERO      = 8'h49;
  localparam logic [7:0] OP_SET_PAN_POS   = 8'h4B;
  localparam logic [7:0] OP_SET_TILT_POS  = 8'h4D;
  localparam logic [7:0] OP_SET_ZOOM_POS  = 8'h4F;
  localparam logic [7:0] OP_QUERY_PAN     = 8'h51;
  localparam logic [7:0] OP_QUERY_TILT    = 8'h53;
  localparam logic [7:0] OP_QUERY_ZOOM    = 8'h55;
  localparam logic [7:0] OP_SET_MAG       = 8'h5F;
  localparam logic [7:0] OP_QUERY_MAG     = 8'h61;
  localparam logic [7:0] OP_TOP           = 8'h63;

  typedef struct packed {
    status_e     status;
    action_e     action;
    logic [7:0]  pan_raw;
    logic [7:0]  tilt_raw;
    logic [7:0]  preset;
    logic [7:0]  aux;
    logic [15:0] position;
    logic [15:0] pan_rate;
    logic [15:0] tilt_rate;
  } decoded_t;

endpackage

module pdfd_result_checker
  import pdfd_pkg::*;
  import pdfd_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [5:0]  action_i,
  input  logic [7:0]  pan_raw_i,
  input  logic [7:0]  tilt_raw_i,
  input  logic [7:0]  preset_number_i,
  input  logic [7:0]  aux_number_i,
  input  logic [15:0] pos_word_i,
  input  logic [15:0] pan_rate_i,
  input  logic [15:0] tilt_rate_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  logic [7:0]       own_address;
  logic [15:0]      pan_min, pan_max, tilt_min, tilt_max;
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_body [BODY_BYTES];
  decoded_t         pending_decodes [$];
  int unsigned      fail_count, checked;

  function automatic logic [15:0] step_rate(input logic [7:0] speed,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    int unsigned s;
    int unsigned span;
    if (speed == 8'h00) return 16'h0000;
    if (speed == SPEED_TURBO) return hi;
    s = (speed > SPEED_TOP) ? SPEED_TOP : speed;
    span = (hi >= lo) ? hi - lo : 0;
    return 16'(lo + (s * span) / SPEED_TOP);
  endfunction

  function automatic string describe(input decoded_t r);
    return $sformatf({"status=%0d action=%0d speed=%02h/%02h preset=%02h aux=%02h",
                      " pos=%04h rate=%0d/%0d"},
                     r.status, r.action, r.pan_raw, r.tilt_raw, r.preset, r.aux,
                     r.position, r.pan_rate, r.tilt_rate);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_t   got;
    decoded_t   want;
    logic [7:0] addr, c1, c2, d1, d2, sum;
    logic       use_preset, use_aux;
    if (!rst_ni) begin
      own_address = OWN_ADDRESS_RST;
      pan_min     = PAN_MIN_RATE_RST;
      pan_max     = PAN_MAX_RATE_RST;
      tilt_min    = TILT_MIN_RATE_RST;
      tilt_max    = TILT_MAX_RATE_RST;
      frame_pos   = '0;
      fail_count  = 0;
      checked     = 0;
      pending_decodes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.status    = status_e'(status_i);
        got.action    = action_e'(action_i);
        got.pan_raw   = pan_raw_i;
        got.tilt_raw  = tilt_raw_i;
        got.preset    = preset_number_i;
        got.aux       = aux_number_i;
        got.position  = pos_word_i;
        got.pan_rate  = pan_rate_i;
        got.tilt_rate = tilt_rate_i;
        if (pending_decodes.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] result with no frame outstanding: %s", $time, describe(got));
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          checked++;
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("[%0t] result %0d mismatch", $time, checked);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            fail_count++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_OWN_ADDRESS:   own_address = cfg_wdata_i[7:0];
          CFG_PAN_MIN_RATE:  pan_min = cfg_wdata_i;
          CFG_PAN_MAX_RATE:  pan_max = cfg_wdata_i;
          CFG_TILT_MIN_RATE: tilt_min = cfg_wdata_i;
          CFG_TILT_MAX_RATE: tilt_max = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (rx_byte_i == SYNC_BYTE) begin
          frame_pos = POS_W'(1);
        end else if (frame_pos == 0) begin
          // Bytes outside a frame are dropped.
        end else if (frame_pos < FRAME_BYTES - 1) begin
          frame_body[frame_pos - 1] = rx_byte_i;
          frame_pos = frame_pos + 1'b1;
        end else begin
          frame_pos = '0;
          addr = frame_body[0];
          c1   = frame_body[1];
          c2   = frame_body[2];
          d1   = frame_body[3];
          d2   = frame_body[4];
          sum  = addr + c1 + c2 + d1 + d2;
          want = '0;
          use_preset = 1'b0;
          use_aux    = 1'b0;
          if (sum != rx_byte_i) begin
            want.status = ST_BAD_CHECKSUM;
          end else if (addr != own_address && addr != 8'h00) begin
            want.status = ST_NOT_OURS;
          end else begin
            want.status    = ST_ACCEPTED;
            want.pan_raw   = d1;
            want.tilt_raw  = d2;
            want.pan_rate  = step_rate(d1, pan_min, pan_max);
            want.tilt_rate = step_rate(d2, tilt_min, tilt_max);
            if (c1 == 8'h00 && c2 != 8'h00 && (c2[0] || c2 >= EXT_MIN_OP)) begin
              want.position = {d1, d2};
              case (c2)
                OP_SET_PRESET:    begin want.action = ACT_SET_PRESET; use_preset = 1'b1; end
                OP_CLEAR_PRESET:  begin want.action = ACT_CLEAR_PRESET; use_preset = 1'b1; end
                OP_GOTO_PRESET: begin
                  if (d2 == HOME_DATA) want.action = ACT_GO_HOME;
                  else if (d2 == FLIP_DATA) want.action = ACT_FLIP;
                  else begin
                    want.action = ACT_GOTO_PRESET;
                    use_preset  = 1'b1;
                  end
                end
                OP_SET_AUX:       begin want.action = ACT_SET_AUX; use_aux = 1'b1; end
                OP_CLEAR_AUX:     begin want.action = ACT_CLEAR_AUX; use_aux = 1'b1; end
                OP_REMOTE_RESET:  want.action = ACT_REMOTE_RESET;
                OP_ZONE_START:    begin want.action = ACT_ZONE_START; use_aux = 1'b1; end
                OP_ZONE_END:      begin want.action = ACT_ZONE_END; use_aux = 1'b1; end
                OP_CLEAR_SCREEN:  want.action = ACT_CLEAR_SCREEN;
                OP_ALARM_ACK:     begin want.action = ACT_ALARM_ACK; use_aux = 1'b1; end
                OP_ZONE_SCAN_ON:  want.action = ACT_ZONE_SCAN_ON;
                OP_ZONE_SCAN_OFF: want.action = ACT_ZONE_SCAN_OFF;
                OP_PATTERN_START: begin want.action = ACT_PATTERN_START; use_preset = 1'b1; end
                OP_PATTERN_STOP:  want.action = ACT_PATTERN_STOP;
                OP_RUN_PATTERN:   begin want.action = ACT_RUN_PATTERN; use_preset = 1'b1; end
                OP_RESET_CAMERA:  want.action = ACT_RESET_CAMERA;
                OP_AUTOFOCUS:     want.action = ACT_AUTOFOCUS;
                OP_AUTO_IRIS:     want.action = ACT_AUTO_IRIS;
                OP_BACKLIGHT:     want.action = ACT_BACKLIGHT;
                OP_AUTO_WB:       want.action = ACT_AUTO_WB;
                OP_SHUTTER:       want.action = ACT_SHUTTER;
                OP_SET_ZERO:      want.action = ACT_SET_ZERO;
                OP_SET_PAN_POS:   want.action = ACT_SET_PAN_POS;
                OP_SET_TILT_POS:  want.action = ACT_SET_TILT_POS;
                OP_SET_ZOOM_POS:  want.action = ACT_SET_ZOOM_POS;
                OP_QUERY_PAN:     want.action = ACT_QUERY_PAN;
                OP_QUERY_TILT:    want.action = ACT_QUERY_TILT;
                OP_QUERY_ZOOM:    want.action = ACT_QUERY_ZOOM;
                OP_SET_MAG:       want.action = ACT_SET_MAG;
                OP_QUERY_MAG:     want.action = ACT_QUERY_MAG;
                default:          want.action = ACT_NONE;
              endcase
              if (use_preset) want.preset = d2;
              if (use_aux) want.aux = d2;
            end else if (c1 == 8'h00 && c2 == 8'h00) begin
              want.action = ACT_STOP;
            end else if (c2[2] && c2[3]) want.action = ACT_UP_LEFT;
            else if (c2[1] && c2[3]) want.action = ACT_UP_RIGHT;
            else if (c2[2] && c2[4]) want.action = ACT_DOWN_LEFT;
            else if (c2[1] && c2[4]) want.action = ACT_DOWN_RIGHT;
            else if (c2[2]) want.action = ACT_PAN_LEFT;
            else if (c2[1]) want.action = ACT_PAN_RIGHT;
            else if (c2[3]) want.action = ACT_TILT_UP;
            else if (c2[4]) want.action = ACT_TILT_DOWN;
            else if (c2[5]) want.action = ACT_ZOOM_IN;
            else if (c2[6]) want.action = ACT_ZOOM_OUT;
            else if (c2[7]) want.action = ACT_FOCUS_FAR;
            else if (c1[1]) want.action = ACT_FOCUS_NEAR;
            else if (c1[2]) want.action = ACT_IRIS_OPEN;
            else if (c1[3]) want.action = ACT_IRIS_CLOSE;
            else if (c1[4]) want.action = c1[7] ? ACT_CAMERA_ON : ACT_CAMERA_OFF;
            else if (c1[5]) want.action = c1[7] ? ACT_AUTO_SCAN_ON : ACT_AUTO_SCAN_OFF;
            else want.action = ACT_NONE;
          end
          pending_decodes.push_back(want);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= pending_decodes.size();
    checked_o    <= checked;
  end

endmodule

### verif/pelco_d_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pelco-D frame decoder testbench
// Feeds the decoder with serial bytes: a directed set of frames for the
// corner cases, sweeps over all command bits and extended opcodes, then
// random frames, broken frames and noise under several address and rate
// settings, with random gaps on the byte side and random stalls on the
// result side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module pelco_d_frame_decoder_unit_tb;

  import pdfd_pkg::*;
  import pdfd_tb_pkg::*;

  localparam int unsigned PHASE_BYTES = 26;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_OWN_ADDRESS;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  action;
  logic [7:0]  pan_raw, tilt_raw, preset_number, aux_number;
  logic [15:0] pos_word, pan_rate, tilt_rate;

  int unsigned fail_count, pending_count, checked_count;
  int unsigned bytes_sent, frames_sent, settings_used;
  int unsigned stall_hold;
  logic [7:0]  cur_address;
  logic        calm;

  always #4 clk = ~clk;

  pelco_d_frame_decoder_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .action_o       (action),
    .pan_raw_o      (pan_raw),
    .tilt_raw_o     (tilt_raw),
    .preset_number_o(preset_number),
    .aux_number_o   (aux_number),
    .pos_word_o     (pos_word),
    .pan_rate_o     (pan_rate),
    .tilt_rate_o    (tilt_rate)
  );

  pdfd_result_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .action_i       (action),
    .pan_raw_i      (pan_raw),
    .tilt_raw_i     (tilt_raw),
    .preset_number_i(preset_number),
    .aux_number_i   (aux_number),
    .pos_word_i     (pos_word),
    .pan_rate_i     (pan_rate),
    .tilt_rate_i    (tilt_rate),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count),
    .checked_o      (checked_count)
  );

  always @(posedge clk) begin : result_stall
    int unsigned pick;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 20);
      end else if (pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(40, 120);
      end else if (pick < 85) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (pick < 96) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(3, 8);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(15, 40);
      end
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_speed();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 8'h00;
    if (pick < 25) return 8'h01;
    if (pick < 35) return SPEED_TOP;
    if (pick < 50) return SPEED_TURBO;
    if (pick < 62) return 8'($urandom_range(8'h41, 8'hFE));
    return 8'($urandom_range(2, 8'h3E));
  endfunction

  function automatic logic [7:0] pick_data2();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return HOME_DATA;
    if (pick < 4) return FLIP_DATA;
    return pick_speed();
  endfunction

  function automatic logic [7:0] pick_address();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return (cur_address == SYNC_BYTE) ? 8'h00 : cur_address;
    if (pick < 70) return 8'h00;
    return 8'($urandom_range(1, 8'hFE));
  endfunction

  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] d1,
                            input logic [7:0] d2, input logic bad_sum);
    logic [7:0] csum;
    csum = addr + c1 + c2 + d1 + d2;
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 8'hFE));
    calm = ($urandom_range(0, 3) == 0);
    put_byte(SYNC_BYTE);
    put_byte(addr);
    put_byte(c1);
    put_byte(c2);
    put_byte(d1);
    put_byte(d2);
    put_byte(csum);
    frames_sent++;
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  c1, c2;
    kind = $urandom_range(0, 99);
    c1 = 8'($urandom_range(0, 8'hFE));
    c2 = 8'($urandom_range(0, 8'hFE));
    if ($urandom_range(0, 1) == 1) c2 = c2 & 8'hE1;
    if (kind < 35) begin
      if ($urandom_range(0, 1) == 1) c2 = 8'($urandom_range(0, OP_TOP / 2) * 2 + 1);
      else c2 = 8'($urandom_range(EXT_MIN_OP, 8'hFE));
      send_frame(pick_address(), 8'h00, c2, pick_speed(), pick_data2(), 1'b0);
    end else if (kind < 42) begin
      send_frame(pick_address(), 8'h00, 8'h00, pick_speed(), pick_speed(), 1'b0);
    end else if (kind < 80) begin
      send_frame(pick_address(), c1, c2, pick_speed(), pick_speed(), 1'b0);
    end else if (kind < 88) begin
      send_frame(pick_address(), c1, c2, pick_speed(), pick_data2(), 1'b1);
    end else if (kind < 94) begin
      // A frame cut short by the sync of the next one.
      put_byte(SYNC_BYTE);
      n = $urandom_range(1, 5);
      repeat (n) put_byte(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) put_byte(8'($urandom_range(0, 8'hFE)));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] addr, input logic [15:0] pmin,
                           input logic [15:0] pmax, input logic [15:0] tmin,
                           input logic [15:0] tmax);
    int unsigned phase_end;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_wdata <= {8'h00, addr};
    @(posedge clk);
    cfg_index <= CFG_PAN_MIN_RATE;
    cfg_wdata <= pmin;
    @(posedge clk);
    cfg_index <= CFG_PAN_MAX_RATE;
    cfg_wdata <= pmax;
    @(posedge clk);
    cfg_index <= CFG_TILT_MIN_RATE;
    cfg_wdata <= tmin;
    @(posedge clk);
    cfg_index <= CFG_TILT_MAX_RATE;
    cfg_wdata <= tmax;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_address = addr;
    settings_used++;
    phase_end = bytes_sent + PHASE_BYTES;
    while (bytes_sent < phase_end) random_frame();
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned phase_end;
    calm = 1'b0;
    cur_address = OWN_ADDRESS_RST;
    settings_used = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_byte(8'h00);
    put_byte(8'hFE);
    put_byte(8'h7F);
    send_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(8'h00, 8'h00, 8'h04, SPEED_TURBO, SPEED_TOP, 1'b0);
    send_frame(8'hFE, 8'h80, 8'h08, 8'h10, 8'h20, 1'b0);
    send_frame(8'h01, 8'h00, 8'h02, 8'h01, 8'h01, 1'b1);
    send_frame(8'h01, 8'h00, OP_GOTO_PRESET, 8'h00, HOME_DATA, 1'b0);
    send_frame(8'h01, 8'h00, OP_GOTO_PRESET, 8'hFE, FLIP_DATA, 1'b0);
    send_frame(8'h00, 8'h00, OP_GOTO_PRESET, 8'h01, 8'hFE, 1'b0);
    send_frame(8'h01, 8'h00, OP_SET_AUX, 8'h41, 8'h80, 1'b0);
    send_frame(8'h01, 8'h00, 8'h01, 8'hFE, 8'h00, 1'b0);
    send_frame(8'h01, 8'h00, 8'hFE, 8'h3E, 8'h02, 1'b0);
    send_frame(8'h01, 8'hFE, 8'hFE, SPEED_TURBO, SPEED_TURBO, 1'b0);
    // A sync in the middle of a frame starts it over.
    put_byte(SYNC_BYTE);
    put_byte(8'h01);
    put_byte(8'h00);
    send_frame(8'h01, 8'h80, 8'h00, 8'h02, 8'h03, 1'b0);
    // The body sums to 0xFF, so the checksum byte is taken as a new sync.
    put_byte(SYNC_BYTE);
    put_byte(8'h01);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h7E);
    put_byte(8'h80);
    put_byte(SYNC_BYTE);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);

    for (k = 1; k <= OP_TOP; k += 2)
      send_frame(cur_address, 8'h00, 8'(k), pick_speed(), pick_data2(), 1'b0);
    for (k = 1; k < 8; k++)
      send_frame(cur_address, {1'($urandom), 7'h00}, 8'(1 << k), pick_speed(),
                 pick_speed(), 1'b0);
    for (k = 0; k < 16; k++)
      send_frame(cur_address, 8'(1 << (k % 8)) | {k[3], 7'h00}, 8'h00, pick_speed(),
                 pick_speed(), 1'b0);
    for (k = 0; k < 4; k++)
      send_frame(cur_address, 8'h00, (k[0] ? 8'h04 : 8'h02) | (k[1] ? 8'h08 : 8'h10),
                 pick_speed(), pick_speed(), 1'b0);
    phase_end = bytes_sent + PHASE_BYTES;
    while (bytes_sent < phase_end) random_frame();

    run_phase(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    run_phase(8'hFE, 16'h1234, 16'h1234, 16'($urandom), 16'($urandom));
    run_phase(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    run_phase(8'($urandom_range(1, 8'hFD)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    run_phase(OWN_ADDRESS_RST, PAN_MIN_RATE_RST, PAN_MAX_RATE_RST, TILT_MIN_RATE_RST,
              TILT_MAX_RATE_RST);

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d complete frames under %0d address/rate settings.",
             bytes_sent, frames_sent, settings_used);
    $display("Compared %0d decoded results, %0d failures.", checked_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("pelco_d_frame_decoder_unit_tb: clean");
    end else begin
      $display("pelco_d_frame_decoder_unit_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Timed out with %0d results outstanding.", pending_count);
    $display("pelco_d_frame_decoder_unit_tb: errors");
    $finish;
  end

endmodule
